>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, register indexes, types and arithmetic helpers for the
// pressure and temperature compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int RAW_W     = 24;
  localparam int SFB       = 24;             // fraction bits of scaled values
  localparam int OFB       = 8;              // fraction bits of the results
  localparam int FLOOR_SH  = SFB - OFB;
  localparam int PA_W      = 40;
  localparam int TC_W      = 28;
  localparam int CAL_W     = 64;
  localparam int CAL2_W    = 16;
  localparam int SCALE_W   = 24;
  localparam int DIV_W     = RAW_W + SFB;    // quotient bits of the scaler
  localparam int ACC_W     = 64;
  localparam int PROD_W    = 2 * ACC_W;
  localparam int MUL_LAT   = 5;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(524288);

  localparam logic [CFG_IDX_W-1:0] CFG_CAL0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PSCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TSCALE = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // One scaled reading pair, as it travels from the scaler to the polynomial.
  typedef struct packed {
    logic signed [ACC_W-1:0] ps;
    logic signed [ACC_W-1:0] ts;
  } item_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coef_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    ov;
  } sum_t;

  // The eighteen calibration bytes lie back to back, byte 0 at the top.
  function automatic coef_t unpack_coefs(input logic [CAL_W-1:0] cal0,
                                         input logic [CAL_W-1:0] cal1,
                                         input logic [CAL2_W-1:0] cal2);
    logic [2*CAL_W+CAL2_W-1:0] b;
    coef_t c;
    b     = {cal0, cal1, cal2};
    c.c0  = b[143:132];
    c.c1  = b[131:120];
    c.c00 = b[119:100];
    c.c10 = b[99:80];
    c.c01 = b[79:64];
    c.c11 = b[63:48];
    c.c20 = b[47:32];
    c.c21 = b[31:16];
    c.c30 = b[15:0];
    return c;
  endfunction

  // Signed add that clamps to the accumulator range and flags the clamp.
  function automatic sum_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    sum_t r;
    s     = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    r.ov  = s[ACC_W] != s[ACC_W-1];
    r.val = r.ov ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider: trunc(raw * 2^SFB / scale), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module ptc_div
  import ptc_pkg::*;
(
  input  logic                       clk,
  input  logic                       en_i,
  input  logic signed [RAW_W-1:0]    raw_i,
  input  logic        [SCALE_W-1:0]  scale_i,
  output logic signed [ACC_W-1:0]    quot_o
);

  logic [SCALE_W-1:0] rem_r [0:DIV_W];
  logic [DIV_W-1:0]   nq_r  [0:DIV_W];
  logic [SCALE_W-1:0] dv_r  [0:DIV_W];
  logic               neg_r [0:DIV_W];

  logic [SCALE_W:0]   tr_w  [0:DIV_W-1];
  logic [SCALE_W-1:0] rn_w  [0:DIV_W-1];
  logic [DIV_W-1:0]   ge_w;
  logic [RAW_W-1:0]   mag_w;
  logic [ACC_W-1:0]   q_w;

  assign mag_w = raw_i[RAW_W-1] ? RAW_W'(-raw_i) : RAW_W'(raw_i);

  always_comb begin
    for (int i = 0; i < DIV_W; i++) begin
      tr_w[i] = {rem_r[i], nq_r[i][DIV_W-1]};
      ge_w[i] = tr_w[i] >= {1'b0, dv_r[i]};
      rn_w[i] = ge_w[i] ? SCALE_W'(tr_w[i] - {1'b0, dv_r[i]}) : tr_w[i][SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_r[0] <= '0;
      nq_r[0]  <= {mag_w, {SFB{1'b0}}};
      dv_r[0]  <= (scale_i == '0) ? SCALE_W'(1) : scale_i;
      neg_r[0] <= raw_i[RAW_W-1];
      for (int i = 0; i < DIV_W; i++) begin
        rem_r[i+1] <= rn_w[i];
        nq_r[i+1]  <= {nq_r[i][DIV_W-2:0], ge_w[i]};
        dv_r[i+1]  <= dv_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign q_w    = ACC_W'(nq_r[DIV_W]);
  assign quot_o = neg_r[DIV_W] ? -$signed(q_w) : $signed(q_w);

endmodule

>>> rtl/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Accepts reading pairs and scales both raw values into fixed point.
// ----------------------------------------------------------------------------
module ptc_front
  import ptc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic signed [RAW_W-1:0]   raw_p_i,
  input  logic signed [RAW_W-1:0]   raw_t_i,
  input  logic        [SCALE_W-1:0] pscale_i,
  input  logic        [SCALE_W-1:0] tscale_i,
  input  logic                      q_full_i,
  input  logic                      q_pop_i,
  output logic                      busy_o,
  output logic                      push_o,
  output item_t                     item_o
);

  logic [DIV_W:0] fv_r;
  logic           adv;

  // The whole scaler holds when its last word cannot enter the queue.
  assign adv    = !(fv_r[DIV_W] && q_full_i && !q_pop_i);
  assign busy_o = !adv;
  assign push_o = fv_r[DIV_W] && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= {fv_r[DIV_W-1:0], start_i};
    end
  end

  ptc_div u_div_p (
    .clk     (clk),
    .en_i    (adv),
    .raw_i   (raw_p_i),
    .scale_i (pscale_i),
    .quot_o  (item_o.ps)
  );

  ptc_div u_div_t (
    .clk     (clk),
    .en_i    (adv),
    .raw_i   (raw_t_i),
    .scale_i (tscale_i),
    .quot_o  (item_o.ts)
  );

endmodule

>>> rtl/ptc_fifo.sv
// ----------------------------------------------------------------------------
// ptc_fifo
// Short queue between the scaler and the polynomial; drained whenever it
// holds a word.
// ----------------------------------------------------------------------------
module ptc_fifo
  import ptc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  pop_o,
  output item_t item_o
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full_o = cnt_r == QCNT_W'(QDEPTH);
  assign pop_o  = cnt_r != '0;
  assign item_o = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop_o) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push_i) - QCNT_W'(pop_o);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o && !pop_o))
    else $error("queue written while full");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCNT_W'(QDEPTH)) || (QPTR_W'(wr_r - rd_r) == cnt_r[QPTR_W-1:0]))
    else $error("queue pointers disagree with fill count");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_o) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

>>> rtl/ptc_mul.sv
// ----------------------------------------------------------------------------
// ptc_mul
// Pipelined 64x64 signed multiply from 32-bit partial products, optionally
// floored by the fraction bits, saturated to 64 bits.
// ----------------------------------------------------------------------------
module ptc_mul
  import ptc_pkg::*;
(
  input  logic                    clk,
  input  logic signed [ACC_W-1:0] a_i,
  input  logic signed [ACC_W-1:0] b_i,
  input  logic                    frac_i,
  output logic signed [ACC_W-1:0] prod_o,
  output logic                    ov_o
);

  logic [ACC_W-1:0]         ua_r, ub_r;
  logic                     neg_a_r, frac_a_r;
  logic [ACC_W-1:0]         p00_r, p01_r, p10_r, p11_r;
  logic                     neg_b_r, frac_b_r;
  logic [PROD_W-1:0]        mag_r;
  logic                     neg_c_r, frac_c_r;
  logic signed [PROD_W-1:0] val_r;
  logic                     frac_d_r;
  logic signed [PROD_W-1:0] sh_w;
  logic                     fit_w;

  assign sh_w  = frac_d_r ? (val_r >>> SFB) : val_r;
  assign fit_w = (sh_w[PROD_W-1:ACC_W-1] == '0) || (sh_w[PROD_W-1:ACC_W-1] == '1);

  always_ff @(posedge clk) begin
    ua_r     <= a_i[ACC_W-1] ? ACC_W'(-a_i) : ACC_W'(a_i);
    ub_r     <= b_i[ACC_W-1] ? ACC_W'(-b_i) : ACC_W'(b_i);
    neg_a_r  <= a_i[ACC_W-1] ^ b_i[ACC_W-1];
    frac_a_r <= frac_i;

    p00_r    <= ACC_W'(ua_r[31:0])  * ACC_W'(ub_r[31:0]);
    p01_r    <= ACC_W'(ua_r[31:0])  * ACC_W'(ub_r[63:32]);
    p10_r    <= ACC_W'(ua_r[63:32]) * ACC_W'(ub_r[31:0]);
    p11_r    <= ACC_W'(ua_r[63:32]) * ACC_W'(ub_r[63:32]);
    neg_b_r  <= neg_a_r;
    frac_b_r <= frac_a_r;

    mag_r    <= PROD_W'(p00_r) + (PROD_W'(p01_r) << 32) + (PROD_W'(p10_r) << 32)
              + (PROD_W'(p11_r) << 64);
    neg_c_r  <= neg_b_r;
    frac_c_r <= frac_b_r;

    val_r    <= neg_c_r ? -$signed(mag_r) : $signed(mag_r);
    frac_d_r <= frac_c_r;

    prod_o   <= fit_w ? sh_w[ACC_W-1:0] : (sh_w[PROD_W-1] ? ACC_MIN : ACC_MAX);
    ov_o     <= !fit_w;
  end

endmodule

>>> rtl/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// Pipelined evaluation of the pressure and temperature polynomials with
// saturation tracking, floor and output clamp.
// ----------------------------------------------------------------------------
module ptc_back
  import ptc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop_i,
  input  item_t                   item_i,
  input  coef_t                   coef_i,
  output logic                    out_valid_o,
  output logic signed [PA_W-1:0]  pressure_o,
  output logic signed [TC_W-1:0]  temp_o,
  output logic                    clipped_o
);

  localparam int T1 = MUL_LAT;
  localparam int T2 = T1 + 1;
  localparam int T3 = T2 + MUL_LAT;
  localparam int T4 = T3 + 1;
  localparam int T5 = T4 + MUL_LAT;
  localparam int T6 = T5 + 1;
  localparam int T7 = T6 + 1;
  localparam int T8 = T7 + 1;

  logic                    vld_r [0:T8];
  logic signed [ACC_W-1:0] ps_r  [0:T4];
  logic signed [ACC_W-1:0] ts_r;
  logic signed [ACC_W-1:0] a_r, d_r, tp_r, bb_r;
  logic signed [ACC_W-1:0] g_r   [T2:T6];
  logic signed [ACC_W-1:0] e_r   [T4:T7];
  logic signed [ACC_W-1:0] t_r   [T2:T8];
  logic                    ov_r  [T2:T8];
  logic signed [ACC_W-1:0] p_r   [T6:T8];

  logic signed [ACC_W-1:0] c0f, c10f, c00f, c11f, c20f;
  logic signed [ACC_W-1:0] m1_p, m2_p, m3_p, m4_p, m5_p, m6_p, m7_p, m8_p;
  logic                    m1_o, m2_o, m3_o, m4_o, m5_o, m6_o, m7_o, m8_o;
  sum_t                    sa, sd, st, sb, sp, sg, se;
  logic signed [ACC_W-1:0] pf, tf;
  logic                    p_fit, t_fit;

  assign c0f  = ACC_W'(coef_i.c0)  <<< (SFB - 1);
  assign c10f = ACC_W'(coef_i.c10) <<< SFB;
  assign c00f = ACC_W'(coef_i.c00) <<< SFB;
  assign c11f = ACC_W'(coef_i.c11) <<< SFB;
  assign c20f = ACC_W'(coef_i.c20) <<< SFB;

  ptc_mul u_m1 (.clk(clk), .a_i(ps_r[0]), .b_i(ACC_W'(coef_i.c30)), .frac_i(1'b0),
                .prod_o(m1_p), .ov_o(m1_o));
  ptc_mul u_m4 (.clk(clk), .a_i(ps_r[0]), .b_i(ACC_W'(coef_i.c21)), .frac_i(1'b0),
                .prod_o(m4_p), .ov_o(m4_o));
  ptc_mul u_m5 (.clk(clk), .a_i(ts_r), .b_i(ps_r[0]), .frac_i(1'b1),
                .prod_o(m5_p), .ov_o(m5_o));
  ptc_mul u_m6 (.clk(clk), .a_i(ts_r), .b_i(ACC_W'(coef_i.c01)), .frac_i(1'b0),
                .prod_o(m6_p), .ov_o(m6_o));
  ptc_mul u_m7 (.clk(clk), .a_i(ts_r), .b_i(ACC_W'(coef_i.c1)), .frac_i(1'b0),
                .prod_o(m7_p), .ov_o(m7_o));
  ptc_mul u_m2 (.clk(clk), .a_i(ps_r[T2]), .b_i(a_r), .frac_i(1'b1),
                .prod_o(m2_p), .ov_o(m2_o));
  ptc_mul u_m8 (.clk(clk), .a_i(tp_r), .b_i(d_r), .frac_i(1'b1),
                .prod_o(m8_p), .ov_o(m8_o));
  ptc_mul u_m3 (.clk(clk), .a_i(ps_r[T4]), .b_i(bb_r), .frac_i(1'b1),
                .prod_o(m3_p), .ov_o(m3_o));

  assign sa = sat_add(c20f, m1_p);
  assign sd = sat_add(c11f, m4_p);
  assign st = sat_add(c0f, m7_p);
  assign sb = sat_add(c10f, m2_p);
  assign sp = sat_add(c00f, m3_p);
  assign sg = sat_add(p_r[T6], g_r[T6]);
  assign se = sat_add(p_r[T7], e_r[T7]);

  assign pf    = p_r[T8] >>> FLOOR_SH;
  assign tf    = t_r[T8] >>> FLOOR_SH;
  assign p_fit = (pf[ACC_W-1:PA_W-1] == '0) || (pf[ACC_W-1:PA_W-1] == '1);
  assign t_fit = (tf[ACC_W-1:TC_W-1] == '0) || (tf[ACC_W-1:TC_W-1] == '1);

  always_ff @(posedge clk) begin
    ps_r[0] <= item_i.ps;
    ts_r    <= item_i.ts;
    for (int k = 0; k < T4; k++) begin
      ps_r[k+1] <= ps_r[k];
    end
    for (int k = T2; k < T6; k++) begin
      g_r[k+1] <= g_r[k];
    end
    for (int k = T4; k < T7; k++) begin
      e_r[k+1] <= e_r[k];
    end
    for (int k = T2; k < T8; k++) begin
      t_r[k+1] <= t_r[k];
    end
    // The overflow flag only rides along while a multiply is in progress.
    for (int k = T2; k < T3; k++) begin
      ov_r[k+1] <= ov_r[k];
    end
    for (int k = T4; k < T5; k++) begin
      ov_r[k+1] <= ov_r[k];
    end

    // First products land: linear terms of both polynomials.
    a_r     <= sa.val;
    d_r     <= sd.val;
    tp_r    <= m5_p;
    g_r[T2] <= m6_p;
    t_r[T2] <= st.val;
    ov_r[T2] <= m1_o | m4_o | m5_o | m6_o | m7_o | sa.ov | sd.ov | st.ov;

    bb_r     <= sb.val;
    e_r[T4]  <= m8_p;
    ov_r[T4] <= ov_r[T3] | m2_o | m8_o | sb.ov;

    p_r[T6]  <= sp.val;
    ov_r[T6] <= ov_r[T5] | m3_o | sp.ov;
    p_r[T7]  <= sg.val;
    ov_r[T7] <= ov_r[T6] | sg.ov;
    p_r[T8]  <= se.val;
    ov_r[T8] <= ov_r[T7] | se.ov;

    pressure_o <= p_fit ? pf[PA_W-1:0]
                        : (pf[ACC_W-1] ? {1'b1, {(PA_W-1){1'b0}}} : {1'b0, {(PA_W-1){1'b1}}});
    temp_o     <= t_fit ? tf[TC_W-1:0]
                        : (tf[ACC_W-1] ? {1'b1, {(TC_W-1){1'b0}}} : {1'b0, {(TC_W-1){1'b1}}});
    clipped_o  <= ov_r[T8] | !p_fit | !t_fit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= T8; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_o <= 1'b0;
    end else begin
      vld_r[0] <= pop_i;
      for (int k = 0; k < T8; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      out_valid_o <= vld_r[T8];
    end
  end

endmodule

>>> rtl/pressure_temperature_compensation_core.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Barometer compensation: scales a raw pressure and temperature pair and
// evaluates the calibration polynomials into pascals and degrees Celsius.
// ----------------------------------------------------------------------------
// The core takes one word (raw pressure and raw temperature) per clock cycle
// and returns one result word per input word, in order. A word is accepted on
// a clock edge where start is high and busy is low. Each result appears for a
// single cycle with out_strobe high and cannot be held off, so the receiver
// must take every result as it comes. A word passes through the bit-per-stage
// scaling dividers (one stage per quotient bit plus a setup stage), the queue
// and the polynomial pipeline, whose depth is set by three dependent
// five-stage 64-bit multiplies. The sustained rate is one word per cycle;
// busy only rises if the queue between the scaler and the polynomial is full,
// which does not happen while the polynomial drains it every cycle. Results
// carry 8 fraction bits, are floored, and saturate; the clipped flag reports
// any clamp, also inside intermediate 64-bit sums and products. Calibration
// and scale registers are written through the cfg port, which is always
// ready, and should only be changed while no word is in flight. A scale
// register holding zero behaves as one.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core
  import ptc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [RAW_W-1:0]     in_raw_pressure,
  input  logic signed [RAW_W-1:0]     in_raw_temperature,
  output logic                        out_strobe,
  output logic signed [PA_W-1:0]      out_pressure_pa,
  output logic signed [TC_W-1:0]      out_temperature_c,
  output logic                        out_clipped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CAL_W-1:0]     cfg_data
);

  logic [CAL_W-1:0]   cal0_r, cal1_r;
  logic [CAL2_W-1:0]  cal2_r;
  logic [SCALE_W-1:0] pscale_r, tscale_r;

  coef_t coefs;
  item_t front_item, queue_item;
  logic  push, pop, q_full;

  assign cfg_ready = 1'b1;

  // Register writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r   <= '0;
      cal1_r   <= '0;
      cal2_r   <= '0;
      pscale_r <= SCALE_RESET;
      tscale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAL0:   cal0_r   <= cfg_data;
        CFG_CAL1:   cal1_r   <= cfg_data;
        CFG_CAL2:   cal2_r   <= cfg_data[CAL2_W-1:0];
        CFG_PSCALE: pscale_r <= cfg_data[SCALE_W-1:0];
        CFG_TSCALE: tscale_r <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The coefficients follow the calibration bytes directly; the user must keep
  // these static while words are in flight, which the block does not enforce.
  assign coefs = unpack_coefs(cal0_r, cal1_r, cal2_r);

  ptc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .raw_p_i  (in_raw_pressure),
    .raw_t_i  (in_raw_temperature),
    .pscale_i (pscale_r),
    .tscale_i (tscale_r),
    .q_full_i (q_full),
    .q_pop_i  (pop),
    .busy_o   (busy),
    .push_o   (push),
    .item_o   (front_item)
  );

  ptc_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .item_i (front_item),
    .full_o (q_full),
    .pop_o  (pop),
    .item_o (queue_item)
  );

  ptc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_i       (pop),
    .item_i      (queue_item),
    .coef_i      (coefs),
    .out_valid_o (out_strobe),
    .pressure_o  (out_pressure_pa),
    .temp_o      (out_temperature_c),
    .clipped_o   (out_clipped)
  );

endmodule
